// File: src/gclp_pkg.sv
// Shared types and constants of the G-code line parser.
package gclp_pkg;

   // Field widths of a result item.
   localparam int OUT_WIDTH    = 32;
   localparam int CODE_WIDTH   = 14;
   localparam int NUM_FIELDS   = 7;
   localparam int SLOT_WIDTH   = 3;

   // Depth of the queue between the classifier and the executor.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Characters of interest.
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_DOT   = 8'd46;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_F     = 8'd70;
   localparam logic [7:0] CHAR_G     = 8'd71;
   localparam logic [7:0] CHAR_I     = 8'd73;
   localparam logic [7:0] CHAR_J     = 8'd74;
   localparam logic [7:0] CHAR_M     = 8'd77;
   localparam logic [7:0] CHAR_R     = 8'd82;
   localparam logic [7:0] CHAR_X     = 8'd88;
   localparam logic [7:0] CHAR_Y     = 8'd89;
   localparam logic [7:0] CHAR_Z     = 8'd90;

   // Value slots, in the order of the present mask.
   localparam logic [SLOT_WIDTH-1:0] SLOT_X   = 3'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_Y   = 3'd1;
   localparam logic [SLOT_WIDTH-1:0] SLOT_Z   = 3'd2;
   localparam logic [SLOT_WIDTH-1:0] SLOT_F   = 3'd3;
   localparam logic [SLOT_WIDTH-1:0] SLOT_R   = 3'd4;
   localparam logic [SLOT_WIDTH-1:0] SLOT_I   = 3'd5;
   localparam logic [SLOT_WIDTH-1:0] SLOT_J   = 3'd6;
   localparam logic [SLOT_WIDTH-1:0] NO_FIELD = 3'd7;

   // Line kinds.
   localparam logic [1:0] KIND_REJECT = 2'd0;
   localparam logic [1:0] KIND_G      = 2'd1;
   localparam logic [1:0] KIND_M      = 2'd2;

   // Machine actions and the M numbers that select them.
   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_MOTORS_OFF   = 3'd1;
   localparam logic [2:0] ACT_ESTOP        = 3'd2;
   localparam logic [2:0] ACT_SET_LIMITS   = 3'd3;
   localparam logic [2:0] ACT_RESET_LIMITS = 3'd4;

   localparam logic [CODE_WIDTH-1:0] CODE_MAX          = 14'd9999;
   localparam logic [CODE_WIDTH-1:0] M_MOTORS_OFF      = 14'd18;
   localparam logic [CODE_WIDTH-1:0] M_ESTOP           = 14'd112;
   localparam logic [CODE_WIDTH-1:0] M_SET_LIMITS      = 14'd50;
   localparam logic [CODE_WIDTH-1:0] M_RESET_LIMITS    = 14'd51;

   // A character after classification.
   typedef struct packed {
      logic                  last;
      logic                  is_nul;
      logic                  is_digit;
      logic [3:0]            digit;
      logic [6:0]            digit_x10;
      logic                  is_blank;
      logic                  is_plus;
      logic                  is_minus;
      logic                  is_dot;
      logic                  is_g;
      logic                  is_m;
      logic                  slot_valid;
      logic [SLOT_WIDTH-1:0] slot;
   } char_class_type;

endpackage

// File: src/gclp_front.sv
// Character classifier: decodes each incoming byte into the flags the executor needs.
module gclp_front
   import gclp_pkg::*;
(
   input  logic [7:0]     char_in,
   input  logic           last_char,
   output char_class_type item
);

   logic [3:0] digit;

   assign digit = char_in[3:0] - CHAR_ZERO[3:0];

   always_comb begin
      item            = '0;
      item.last       = last_char;
      item.is_nul     = (char_in == CHAR_NUL);
      item.is_digit   = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      item.digit      = item.is_digit ? digit : 4'd0;
      item.digit_x10  = 7'({item.digit, 3'b000}) + 7'({item.digit, 1'b0});
      item.is_blank   = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
      item.is_plus    = (char_in == CHAR_PLUS);
      item.is_minus   = (char_in == CHAR_MINUS);
      item.is_dot     = (char_in == CHAR_DOT);
      item.is_g       = (char_in == CHAR_G);
      item.is_m       = (char_in == CHAR_M);
      item.slot_valid = 1'b1;
      item.slot       = NO_FIELD;
      unique case (char_in)
         CHAR_X:  item.slot = SLOT_X;
         CHAR_Y:  item.slot = SLOT_Y;
         CHAR_Z:  item.slot = SLOT_Z;
         CHAR_F:  item.slot = SLOT_F;
         CHAR_R:  item.slot = SLOT_R;
         CHAR_I:  item.slot = SLOT_I;
         CHAR_J:  item.slot = SLOT_J;
         default: item.slot_valid = 1'b0;
      endcase
   end

endmodule

// File: src/gclp_queue.sv
// Short queue of classified characters between the classifier and the executor.
module gclp_queue
   import gclp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  char_class_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output char_class_type head_item
);

   char_class_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0]     count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // The depth is a power of two, so the pointers wrap by themselves.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/gclp_back.sv
// Line executor: runs the parse state per character and registers one result per line.
module gclp_back
   import gclp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  char_class_type               q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_line_kind,
   output logic [CODE_WIDTH-1:0]        rsp_code_number,
   output logic signed [OUT_WIDTH-1:0]  rsp_x_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_y_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_z_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_feed_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_radius_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_arc_i_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_arc_j_tenths,
   output logic [NUM_FIELDS-1:0]        rsp_present_mask,
   output logic [2:0]                   rsp_machine_action
);

   localparam int SUM_WIDTH  = VALUE_WIDTH + 4;
   localparam int ADD_WIDTH  = VALUE_WIDTH + 1;
   localparam int NCODE_WIDTH = CODE_WIDTH + 4;
   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   // Position in the line.
   localparam logic [1:0] CI_FIRST      = 2'd0;
   localparam logic [1:0] CI_CODE_START = 2'd1;
   localparam logic [1:0] CI_CODE       = 2'd2;

   // Number scanner states.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_PRE    = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_INT    = 3'd3;
   localparam logic [2:0] PH_DOT    = 3'd4;
   localparam logic [2:0] PH_FRAC   = 3'd5;

   logic [1:0]                  ci_ff, ci_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [CODE_WIDTH-1:0]       code_ff, code_in;
   logic                        code_done_ff, code_done_in;
   logic [VALUE_WIDTH-1:0]      mag_ff [NUM_FIELDS];
   logic [VALUE_WIDTH-1:0]      mag_in [NUM_FIELDS];
   logic [NUM_FIELDS-1:0]       fneg_ff, fneg_in;
   logic [NUM_FIELDS-1:0]       seen_ff, seen_in;
   logic [SLOT_WIDTH-1:0]       af_ff, af_in;
   logic [2:0]                  phase_ff, phase_in;
   logic                        neg_ff, neg_in;
   logic                        stop_ff, stop_in;

   logic                        out_valid_ff, out_valid_in;
   logic [1:0]                  out_kind_ff, out_kind_in;
   logic [CODE_WIDTH-1:0]       out_code_ff, out_code_in;
   logic [OUT_WIDTH-1:0]        out_mag_ff [NUM_FIELDS];
   logic [OUT_WIDTH-1:0]        out_mag_in [NUM_FIELDS];
   logic [NUM_FIELDS-1:0]       out_neg_ff, out_neg_in;
   logic [NUM_FIELDS-1:0]       out_mask_ff, out_mask_in;
   logic [2:0]                  out_action_ff, out_action_in;

   logic [OUT_WIDTH-1:0]        out_val [NUM_FIELDS];

   logic [VALUE_WIDTH-1:0]      cur;
   logic [SUM_WIDTH-1:0]        wide10;
   logic [ADD_WIDTH-1:0]        wide1;
   logic [VALUE_WIDTH-1:0]      sat10, sat1;
   logic [NCODE_WIDTH-1:0]      code_wide;
   logic [CODE_WIDTH-1:0]       code_sat;
   logic                        wr10, wr1, end_req, open_slot, body, cont;
   logic [NUM_FIELDS-1:0]       fin_neg;
   logic [1:0]                  fin_kind;

   // A line-ending item waits until the output register can take its result.
   assign q_pop = q_valid && (!q_item.last || !out_valid_ff || rsp_ready);

   // Value of the active field, advanced by one digit in either part.
   always_comb begin
      cur = '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         if (af_ff == SLOT_WIDTH'(k)) begin
            cur = mag_ff[k];
         end
      end
      wide10 = SUM_WIDTH'({cur, 3'b000}) + SUM_WIDTH'({cur, 1'b0})
             + SUM_WIDTH'(q_item.digit_x10);
      sat10  = (wide10 > SUM_WIDTH'(VAL_MAX)) ? VAL_MAX : wide10[VALUE_WIDTH-1:0];
      wide1  = ADD_WIDTH'(cur) + ADD_WIDTH'(q_item.digit);
      sat1   = (wide1 > ADD_WIDTH'(VAL_MAX)) ? VAL_MAX : wide1[VALUE_WIDTH-1:0];

      code_wide = NCODE_WIDTH'({code_ff, 3'b000}) + NCODE_WIDTH'({code_ff, 1'b0})
                + NCODE_WIDTH'(q_item.digit);
      code_sat  = (code_wide > NCODE_WIDTH'(CODE_MAX)) ? CODE_MAX
                                                       : code_wide[CODE_WIDTH-1:0];
   end

   always_comb begin
      ci_in        = ci_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      code_done_in = code_done_ff;
      mag_in       = mag_ff;
      fneg_in      = fneg_ff;
      seen_in      = seen_ff;
      af_in        = af_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      stop_in      = stop_ff;

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_code_in   = out_code_ff;
      out_mag_in    = out_mag_ff;
      out_neg_in    = out_neg_ff;
      out_mask_in   = out_mask_ff;
      out_action_in = out_action_ff;

      wr10      = 1'b0;
      wr1       = 1'b0;
      end_req   = 1'b0;
      open_slot = 1'b0;
      body      = 1'b0;
      cont      = 1'b1;
      fin_neg   = '0;
      fin_kind  = KIND_REJECT;

      if (q_pop && !stop_ff) begin
         if (q_item.is_nul) begin
            if (ci_ff != CI_CODE) begin
               kind_in = KIND_REJECT;
            end
            end_req = 1'b1;
            stop_in = 1'b1;
         end else if (ci_ff == CI_FIRST) begin
            kind_in = q_item.is_g ? KIND_G : (q_item.is_m ? KIND_M : KIND_REJECT);
            ci_in   = CI_CODE_START;
         end else if (kind_ff != KIND_REJECT) begin
            if (ci_ff == CI_CODE_START) begin
               if (q_item.is_digit) begin
                  code_in = CODE_WIDTH'(q_item.digit);
                  ci_in   = CI_CODE;
               end else begin
                  kind_in = KIND_REJECT;
               end
            end else begin
               if (!code_done_ff) begin
                  if (q_item.is_digit) begin
                     code_in = code_sat;
                     cont    = 1'b0;
                  end else begin
                     code_done_in = 1'b1;
                  end
               end
               if (cont && kind_ff == KIND_G) begin
                  if (q_item.slot_valid) begin
                     end_req   = 1'b1;
                     open_slot = !seen_ff[q_item.slot];
                  end else begin
                     unique case (phase_ff) inside
                        PH_PRE: begin
                           if (q_item.is_blank) begin
                              // Leading blanks before the number are skipped.
                           end else if (q_item.is_plus) begin
                              phase_in = PH_SIGNED;
                           end else if (q_item.is_minus) begin
                              neg_in   = 1'b1;
                              phase_in = PH_SIGNED;
                           end else begin
                              body = 1'b1;
                           end
                        end
                        PH_SIGNED, PH_INT: body = 1'b1;
                        PH_DOT: begin
                           if (q_item.is_digit) begin
                              wr1      = 1'b1;
                              phase_in = PH_FRAC;
                           end else begin
                              end_req = 1'b1;
                           end
                        end
                        PH_FRAC: begin
                           if (!q_item.is_digit) begin
                              end_req = 1'b1;
                           end
                        end
                        default: begin
                        end
                     endcase
                     if (body) begin
                        if (q_item.is_digit) begin
                           wr10     = 1'b1;
                           phase_in = PH_INT;
                        end else if (q_item.is_dot) begin
                           phase_in = PH_DOT;
                        end else begin
                           end_req = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end

      for (int k = 0; k < NUM_FIELDS; k++) begin
         if (af_ff == SLOT_WIDTH'(k)) begin
            if (wr10) begin
               mag_in[k] = sat10;
            end else if (wr1) begin
               mag_in[k] = sat1;
            end
         end
      end

      // Closing a number fixes the sign of its field.
      if (end_req) begin
         for (int k = 0; k < NUM_FIELDS; k++) begin
            if (phase_ff != PH_IDLE && neg_ff && af_ff == SLOT_WIDTH'(k)) begin
               fneg_in[k] = 1'b1;
            end
         end
         phase_in = PH_IDLE;
         af_in    = NO_FIELD;
         neg_in   = 1'b0;
      end

      if (open_slot) begin
         for (int k = 0; k < NUM_FIELDS; k++) begin
            if (q_item.slot == SLOT_WIDTH'(k)) begin
               seen_in[k] = 1'b1;
               mag_in[k]  = '0;
               fneg_in[k] = 1'b0;
            end
         end
         af_in    = q_item.slot;
         phase_in = PH_PRE;
      end

      if (q_pop && q_item.last) begin
         fin_neg = fneg_in;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            if (phase_in != PH_IDLE && neg_in && af_in == SLOT_WIDTH'(k)) begin
               fin_neg[k] = 1'b1;
            end
         end
         fin_kind = (kind_in != KIND_REJECT && ci_in == CI_CODE) ? kind_in : KIND_REJECT;

         out_valid_in  = 1'b1;
         out_kind_in   = fin_kind;
         out_code_in   = (fin_kind != KIND_REJECT) ? code_in : '0;
         out_neg_in    = (fin_kind == KIND_G) ? fin_neg : '0;
         out_mask_in   = (fin_kind == KIND_G) ? seen_in : '0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            out_mag_in[k] = (fin_kind == KIND_G) ? OUT_WIDTH'(mag_in[k]) : '0;
         end
         out_action_in = ACT_NONE;
         if (fin_kind == KIND_M) begin
            unique case (code_in)
               M_MOTORS_OFF:   out_action_in = ACT_MOTORS_OFF;
               M_ESTOP:        out_action_in = ACT_ESTOP;
               M_SET_LIMITS:   out_action_in = ACT_SET_LIMITS;
               M_RESET_LIMITS: out_action_in = ACT_RESET_LIMITS;
               default:        out_action_in = ACT_NONE;
            endcase
         end

         // The line is finished: every line register starts over.
         ci_in        = CI_FIRST;
         kind_in      = KIND_REJECT;
         code_in      = '0;
         code_done_in = 1'b0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            mag_in[k] = '0;
         end
         fneg_in  = '0;
         seen_in  = '0;
         af_in    = NO_FIELD;
         phase_in = PH_IDLE;
         neg_in   = 1'b0;
         stop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff        <= CI_FIRST;
         kind_ff      <= KIND_REJECT;
         code_ff      <= '0;
         code_done_ff <= 1'b0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            mag_ff[k] <= '0;
         end
         fneg_ff      <= '0;
         seen_ff      <= '0;
         af_ff        <= NO_FIELD;
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ci_ff        <= ci_in;
         kind_ff      <= kind_in;
         code_ff      <= code_in;
         code_done_ff <= code_done_in;
         mag_ff       <= mag_in;
         fneg_ff      <= fneg_in;
         seen_ff      <= seen_in;
         af_ff        <= af_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         stop_ff      <= stop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_code_ff   <= out_code_in;
      out_mag_ff    <= out_mag_in;
      out_neg_ff    <= out_neg_in;
      out_mask_ff   <= out_mask_in;
      out_action_ff <= out_action_in;
   end

   // The magnitude is held unsigned; the sign is applied on the way out.
   always_comb begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
         out_val[k] = out_neg_ff[k] ? (OUT_WIDTH'(0) - out_mag_ff[k]) : out_mag_ff[k];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_line_kind      = out_kind_ff;
   assign rsp_code_number    = out_code_ff;
   assign rsp_x_tenths       = out_val[SLOT_X];
   assign rsp_y_tenths       = out_val[SLOT_Y];
   assign rsp_z_tenths       = out_val[SLOT_Z];
   assign rsp_feed_tenths    = out_val[SLOT_F];
   assign rsp_radius_tenths  = out_val[SLOT_R];
   assign rsp_arc_i_tenths   = out_val[SLOT_I];
   assign rsp_arc_j_tenths   = out_val[SLOT_J];
   assign rsp_present_mask   = out_mask_ff;
   assign rsp_machine_action = out_action_ff;

endmodule

// File: src/gcode_line_parser.sv
// Top level of the G-code line parser: classifier, character queue and executor.
// The parser takes one character item per clock cycle, sustained while the result side takes
// each result, and raises rsp_valid for a line once the executor has popped the item carrying
// the last character from the queue and registered the result in its output register.
// Each character is classified on entry and placed in a two-entry queue; the executor then
// advances the line state by one character per cycle, which sets the rate. The executor
// holds a line-ending character only while the output register still holds an untaken
// result, so a stalled result side fills the queue before req_ready falls. Values are kept
// as VALUE_WIDTH-bit magnitudes saturating at 2^(VALUE_WIDTH-1)-1 and are given out as
// 32-bit two's complement.
module gcode_line_parser
   import gclp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_char_in,
   input  logic                         req_last_char,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_line_kind,
   output logic [CODE_WIDTH-1:0]        rsp_code_number,
   output logic signed [OUT_WIDTH-1:0]  rsp_x_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_y_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_z_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_feed_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_radius_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_arc_i_tenths,
   output logic signed [OUT_WIDTH-1:0]  rsp_arc_j_tenths,
   output logic [NUM_FIELDS-1:0]        rsp_present_mask,
   output logic [2:0]                   rsp_machine_action
);

   char_class_type in_item;
   char_class_type head_item;
   logic           q_full;
   logic           q_valid;
   logic           q_pop;

   assign req_ready = !q_full;

   gclp_front u_front (
      .char_in   (req_char_in),
      .last_char (req_last_char),
      .item      (in_item)
   );

   gclp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (in_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   gclp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_kind      (rsp_line_kind),
      .rsp_code_number    (rsp_code_number),
      .rsp_x_tenths       (rsp_x_tenths),
      .rsp_y_tenths       (rsp_y_tenths),
      .rsp_z_tenths       (rsp_z_tenths),
      .rsp_feed_tenths    (rsp_feed_tenths),
      .rsp_radius_tenths  (rsp_radius_tenths),
      .rsp_arc_i_tenths   (rsp_arc_i_tenths),
      .rsp_arc_j_tenths   (rsp_arc_j_tenths),
      .rsp_present_mask   (rsp_present_mask),
      .rsp_machine_action (rsp_machine_action)
   );

endmodule
